### src/oita_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oita_pkg
// Shared widths, operation codes and controller/datapath interface types for
// the object id table allocator.
// ----------------------------------------------------------------------------
package oita_pkg;

    localparam int DEF_ID_BITS = 16;
    localparam int FUNC_W      = 3;
    localparam int OBJ_ID_W    = 16;
    localparam int VALUE_W     = 32;

    localparam int S_FIELDS_W  = FUNC_W + OBJ_ID_W + 2 * VALUE_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W  = OBJ_ID_W + VALUE_W + 2;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_GET     = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SET     = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CMPXCHG = 3'd4;

    localparam logic [VALUE_W-1:0] NULL_LINK = '1;

    typedef struct packed {
        logic init_wr;
        logic accept;
        logic exec;
    } oita_cmd_t;

    typedef struct packed {
        logic init_last;
        logic out_busy;
    } oita_sts_t;

endpackage

### src/oita_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oita_dp
// Entry table memory, free list head, init pass counter, operation logic and
// the result word register.
// ----------------------------------------------------------------------------
module oita_dp #(
    parameter int ID_BITS = oita_pkg::DEF_ID_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  oita_pkg::oita_cmd_t           cmd,
    output oita_pkg::oita_sts_t           sts,
    input  logic [oita_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [oita_pkg::M_TDATA_W-1:0] m_tdata
);
    import oita_pkg::*;

    localparam int DEPTH = 1 << ID_BITS;

    logic [VALUE_W-1:0]  mem [DEPTH];

    logic [ID_BITS-1:0]  init_cnt_reg;
    logic [VALUE_W-1:0]  head_reg, head_next;
    logic [FUNC_W-1:0]   func_reg;
    logic [ID_BITS-1:0]  id_reg;
    logic [VALUE_W-1:0]  val_reg, exp_reg, rdata_reg;

    logic                m_tvalid_reg;
    logic [OBJ_ID_W-1:0] new_id_reg, new_id_next;
    logic [VALUE_W-1:0]  value_out_reg, value_out_next;
    logic                success_reg, success_next;
    logic                oom_reg, oom_next;

    logic [FUNC_W-1:0]   s_func;
    logic [ID_BITS-1:0]  s_id;
    logic [ID_BITS-1:0]  head_idx;
    logic [ID_BITS-1:0]  rd_addr;
    logic                wr_en, op_wr;
    logic [ID_BITS-1:0]  wr_addr, op_addr;
    logic [VALUE_W-1:0]  wr_data, op_data;

    assign s_func   = s_tdata[FUNC_W-1:0];
    assign s_id     = ID_BITS'(s_tdata[FUNC_W +: OBJ_ID_W]);
    assign head_idx = head_reg[ID_BITS-1:0];
    assign rd_addr  = (s_func == FUNC_ALLOC) ? head_idx : s_id;

    always_comb begin
        op_wr          = 1'b0;
        op_addr        = id_reg;
        op_data        = val_reg;
        head_next      = head_reg;
        new_id_next    = '0;
        value_out_next = '0;
        success_next   = 1'b0;
        oom_next       = 1'b0;
        case (func_reg)
            FUNC_ALLOC: begin
                if (head_reg == NULL_LINK) begin
                    oom_next = 1'b1;
                end else begin
                    op_wr        = 1'b1;
                    op_addr      = head_idx;
                    head_next    = rdata_reg;
                    new_id_next  = OBJ_ID_W'(head_idx);
                    success_next = 1'b1;
                end
            end
            FUNC_FREE: begin
                op_wr        = 1'b1;
                op_data      = head_reg;
                head_next    = VALUE_W'(id_reg);
                success_next = 1'b1;
            end
            FUNC_GET: begin
                value_out_next = rdata_reg;
                success_next   = 1'b1;
            end
            FUNC_SET: begin
                op_wr        = 1'b1;
                success_next = 1'b1;
            end
            FUNC_CMPXCHG: begin
                if (rdata_reg == exp_reg) begin
                    op_wr        = 1'b1;
                    success_next = 1'b1;
                end else begin
                    value_out_next = rdata_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (cmd.init_wr) begin
            wr_en   = 1'b1;
            wr_addr = init_cnt_reg;
            wr_data = (&init_cnt_reg) ? NULL_LINK
                                      : VALUE_W'(init_cnt_reg) + VALUE_W'(1);
        end else begin
            wr_en   = cmd.exec & op_wr;
            wr_addr = op_addr;
            wr_data = op_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.accept) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_cnt_reg <= '0;
            head_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.init_wr) begin
                init_cnt_reg <= init_cnt_reg + ID_BITS'(1);
            end
            if (cmd.exec) begin
                head_reg     <= head_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg <= s_func;
            id_reg   <= s_id;
            val_reg  <= s_tdata[FUNC_W + OBJ_ID_W +: VALUE_W];
            exp_reg  <= s_tdata[FUNC_W + OBJ_ID_W + VALUE_W +: VALUE_W];
        end
        if (cmd.exec) begin
            new_id_reg    <= new_id_next;
            value_out_reg <= value_out_next;
            success_reg   <= success_next;
            oom_reg       <= oom_next;
        end
    end

    assign sts.init_last = &init_cnt_reg;
    assign sts.out_busy  = m_tvalid_reg & ~m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - M_FIELDS_W){1'b0}},
                       oom_reg, success_reg, value_out_reg, new_id_reg};

endmodule

### src/oita_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oita_ctrl
// Sequencer: table init pass after reset, then accept / execute per word.
// ----------------------------------------------------------------------------
module oita_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output oita_pkg::oita_cmd_t cmd,
    input  oita_pkg::oita_sts_t sts
);
    import oita_pkg::*;

    localparam logic [1:0] ST_INIT = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.init_wr = 1'b0;
        cmd.accept  = 1'b0;
        cmd.exec    = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.init_wr = 1'b1;
                if (sts.init_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!sts.out_busy) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_accept_then_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> state_reg == ST_EXEC)
        else $error("accepted word did not move to execute");
    a_no_accept_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.init_wr |-> !s_tready && !cmd.accept && !cmd.exec)
        else $error("word taken during table init");
    a_exec_output_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> !sts.out_busy)
        else $error("result overwrote a pending output word");
    a_exec_follows_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> state_reg == ST_EXEC)
        else $error("execute outside execute state");
`endif

endmodule

### src/object_id_table_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// object_id_table_allocator
// Table of 32-bit entries indexed by object id, with free entries chained
// through the table and a head register naming the first free entry.
//
// s_ channel takes one operation word (alloc, free, get, set, cmpxchg);
// m_ channel returns exactly one result word per operation, in order.
// An accepted word reads the table at the accept edge and writes it back in
// the execute step, when the result word is loaded; no new word is accepted
// until then, since the write-back has to wait for the synchronous table read.
// Result is valid on m_ once the execute step has loaded the result word.
// After reset the block runs an init pass over all 2^ID_BITS entries, with
// s_tready low, linking each entry to the next and the last one to null.
// A stalled m_ side holds the result word; one further word is accepted and
// waits in the execute step until the result register frees up.
// ----------------------------------------------------------------------------
module object_id_table_allocator #(
    parameter int ID_BITS = oita_pkg::DEF_ID_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // func[2:0], object_id[18:3], value_in[50:19], expected[82:51], pad
    input  logic [oita_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // new_id[15:0], value_out[47:16], success[48], out_of_memory[49], pad
    output logic [oita_pkg::M_TDATA_W-1:0] m_tdata
);
    import oita_pkg::*;

    oita_cmd_t cmd;
    oita_sts_t sts;

    oita_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    oita_dp #(
        .ID_BITS (ID_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### tb/object_id_table_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// object_id_table_allocator_tb
// Self-checking bench for the object id table allocator. A shadow copy of the
// entry table and free head predicts one result word per operation word. The
// run covers the reset chain, alloc/free including double free and an
// out-of-range head, the empty free list, compare-exchange hits and misses,
// and unknown operation codes. It then holds off the result side until the
// block stalls its input, and ends with a long random mix under random idling
// on both sides.
// ----------------------------------------------------------------------------
module object_id_table_allocator_tb;
    import oita_pkg::*;

    localparam int ID_BITS  = DEF_ID_BITS;
    localparam int TBL_SIZE = 1 << ID_BITS;
    localparam logic [FUNC_W-1:0] FUNC_RSVD_FIRST = FUNC_CMPXCHG + FUNC_W'(1);
    localparam logic [FUNC_W-1:0] FUNC_RSVD_LAST  = '1;

    typedef struct packed {
        logic [OBJ_ID_W-1:0] new_id;
        logic [VALUE_W-1:0]  value_out;
        logic                success;
        logic                out_of_memory;
    } reply_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [VALUE_W-1:0]  entry_mem [TBL_SIZE];
    logic [VALUE_W-1:0]  head_ptr;
    reply_t              table_replies [$];
    logic [OBJ_ID_W-1:0] live_ids [$];

    int errors          = 0;
    int replies_checked = 0;
    int ops_sent        = 0;
    int alloc_hits      = 0;
    int oom_hits        = 0;
    int cas_hits        = 0;
    int cas_misses      = 0;
    int sender_busy_pct = 0;
    int recv_busy_pct   = 0;
    int hold_off        = 0;

    object_id_table_allocator #(
        .ID_BITS(ID_BITS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic reply_t run_table_op(input logic [FUNC_W-1:0] func,
                                            input logic [OBJ_ID_W-1:0] obj,
                                            input logic [VALUE_W-1:0] val,
                                            input logic [VALUE_W-1:0] cmp);
        reply_t             r;
        logic [ID_BITS-1:0] idx;
        logic [ID_BITS-1:0] slot;
        r   = '0;
        idx = ID_BITS'(obj);
        case (func)
            FUNC_ALLOC: begin
                if (head_ptr == NULL_LINK) begin
                    r.out_of_memory = 1'b1;
                end else begin
                    slot            = ID_BITS'(head_ptr);
                    head_ptr        = entry_mem[slot];
                    entry_mem[slot] = val;
                    r.new_id        = OBJ_ID_W'(slot);
                    r.success       = 1'b1;
                end
            end
            FUNC_FREE: begin
                entry_mem[idx] = head_ptr;
                head_ptr       = VALUE_W'(idx);
                r.success      = 1'b1;
            end
            FUNC_GET: begin
                r.value_out = entry_mem[idx];
                r.success   = 1'b1;
            end
            FUNC_SET: begin
                entry_mem[idx] = val;
                r.success      = 1'b1;
            end
            FUNC_CMPXCHG: begin
                if (entry_mem[idx] == cmp) begin
                    entry_mem[idx] = val;
                    r.success      = 1'b1;
                end else begin
                    r.value_out = entry_mem[idx];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int pick_gap(input int busy_pct);
        int r;
        if (busy_pct == 0 || $urandom_range(99) >= busy_pct) begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 85) begin
            return $urandom_range(3, 1);
        end else if (r < 97) begin
            return $urandom_range(12, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [VALUE_W-1:0] rand_word();
        int r;
        r = $urandom_range(9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end
        return $urandom;
    endfunction

    function automatic logic [OBJ_ID_W-1:0] any_id();
        int r;
        r = $urandom_range(15);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return OBJ_ID_W'(TBL_SIZE - 1);
        end
        return OBJ_ID_W'($urandom_range(TBL_SIZE - 1));
    endfunction

    function automatic logic [OBJ_ID_W-1:0] live_or_any();
        if (live_ids.size() > 0 && $urandom_range(4) != 0) begin
            return live_ids[$urandom_range(live_ids.size() - 1)];
        end
        return any_id();
    endfunction

    task automatic reset_table_model();
        for (int i = 0; i < TBL_SIZE - 1; i++) begin
            entry_mem[i] = VALUE_W'(i + 1);
        end
        entry_mem[TBL_SIZE-1] = NULL_LINK;
        head_ptr = '0;
    endtask

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        errors++;
        if (errors <= 40) begin
            $display("%0t ns: %s on result word %0d: got %h, want %h",
                     $time, what, replies_checked, got, want);
        end
    endtask

    task automatic send_op(input logic [FUNC_W-1:0] func, input logic [OBJ_ID_W-1:0] obj,
                           input logic [VALUE_W-1:0] val, input logic [VALUE_W-1:0] cmp,
                           output reply_t r);
        logic [S_TDATA_W-1:0] word;
        int                   gap;
        word = S_TDATA_W'({cmp, val, obj, func});
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        r = run_table_op(func, obj, val, cmp);
        table_replies.push_back(r);
        ops_sent++;
        if (func == FUNC_ALLOC) begin
            if (r.success) alloc_hits++;
            else oom_hits++;
        end
        if (func == FUNC_CMPXCHG) begin
            if (r.success) cas_hits++;
            else cas_misses++;
        end
        gap = pick_gap(sender_busy_pct);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (table_replies.size() != 0) @(posedge aclk);
    endtask

    task automatic test_reset_chain();
        reply_t r;
        send_op(FUNC_GET, '0, '0, '0, r);
        send_op(FUNC_GET, OBJ_ID_W'(1), '1, '1, r);
        send_op(FUNC_GET, OBJ_ID_W'(TBL_SIZE / 2), '0, '0, r);
        send_op(FUNC_GET, OBJ_ID_W'(TBL_SIZE - 1), '0, '0, r);
        wait_drained();
    endtask

    task automatic test_alloc_free();
        reply_t r;
        send_op(FUNC_ALLOC, '0, '1, '0, r);
        send_op(FUNC_ALLOC, '1, '0, '1, r);
        // plant a head link with bits above the id range
        send_op(FUNC_SET, OBJ_ID_W'(head_ptr), 32'hABCD_1234, '0, r);
        send_op(FUNC_ALLOC, '0, 32'h0000_0001, '0, r);
        send_op(FUNC_ALLOC, '0, 32'h0000_0002, '0, r);
        // double free of the same id
        send_op(FUNC_FREE, '0, '0, '0, r);
        send_op(FUNC_FREE, '0, '0, '0, r);
        send_op(FUNC_ALLOC, '0, 32'h0000_0003, '0, r);
        wait_drained();
    endtask

    task automatic test_out_of_memory();
        reply_t r;
        send_op(FUNC_SET, OBJ_ID_W'(head_ptr), NULL_LINK, '0, r);
        send_op(FUNC_ALLOC, '0, 32'h5555_AAAA, '0, r);
        send_op(FUNC_ALLOC, '1, '1, '1, r);
        send_op(FUNC_ALLOC, '0, '0, '0, r);
        send_op(FUNC_FREE, OBJ_ID_W'(TBL_SIZE - 1), '0, '0, r);
        send_op(FUNC_ALLOC, '0, 32'h0F0F_F0F0, '0, r);
        // rebuild a long chain: 3 -> 4 -> 5 ...
        send_op(FUNC_FREE, OBJ_ID_W'(3), '0, '0, r);
        send_op(FUNC_SET, OBJ_ID_W'(3), VALUE_W'(4), '0, r);
        wait_drained();
    endtask

    task automatic test_cmpxchg();
        reply_t r;
        send_op(FUNC_CMPXCHG, OBJ_ID_W'(5), '0, entry_mem[5], r);
        send_op(FUNC_CMPXCHG, OBJ_ID_W'(5), '1, VALUE_W'(6), r);
        send_op(FUNC_CMPXCHG, OBJ_ID_W'(TBL_SIZE - 1), '1, '1, r);
        wait_drained();
    endtask

    task automatic test_unknown_func();
        reply_t r;
        for (int f = FUNC_RSVD_FIRST; f <= FUNC_RSVD_LAST; f++) begin
            send_op(FUNC_W'(f), '1, '1, '1, r);
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        reply_t r;
        sender_busy_pct = 0;
        recv_busy_pct   = 0;
        hold_off        = 400;
        for (int i = 0; i < 12; i++) begin
            send_op((i % 2 == 0) ? FUNC_SET : FUNC_GET, OBJ_ID_W'(100 + i / 2),
                    rand_word(), '0, r);
        end
        wait_drained();
    endtask

    task automatic test_random_mix(input int n);
        reply_t               r;
        int                   pick;
        int                   k;
        logic [FUNC_W-1:0]    func;
        logic [OBJ_ID_W-1:0]  obj;
        logic [VALUE_W-1:0]   val;
        logic [VALUE_W-1:0]   cmp;
        for (int i = 0; i < n; i++) begin
            if (i % 100 == 0) begin
                sender_busy_pct = 20 * $urandom_range(2);
                recv_busy_pct   = 20 * $urandom_range(2);
            end
            pick = $urandom_range(99);
            obj  = any_id();
            val  = rand_word();
            cmp  = rand_word();
            if (pick < 25) begin
                func = FUNC_ALLOC;
            end else if (pick < 40) begin
                func = FUNC_FREE;
                if (live_ids.size() > 0 && $urandom_range(9) != 0) begin
                    k   = $urandom_range(live_ids.size() - 1);
                    obj = live_ids[k];
                    live_ids.delete(k);
                end
            end else if (pick < 58) begin
                func = FUNC_GET;
                obj  = live_or_any();
            end else if (pick < 72) begin
                func = FUNC_SET;
                obj  = live_or_any();
            end else if (pick < 94) begin
                func = FUNC_CMPXCHG;
                obj  = live_or_any();
                if ($urandom_range(1) == 1) cmp = entry_mem[ID_BITS'(obj)];
            end else begin
                func = FUNC_W'($urandom_range(FUNC_RSVD_LAST));
            end
            send_op(func, obj, val, cmp, r);
            if (func == FUNC_ALLOC && r.success) live_ids.push_back(r.new_id);
        end
        wait_drained();
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off > 0) begin
                hold_off--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                stall_left = pick_gap(recv_busy_pct);
                if (stall_left > 0) begin
                    stall_left--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        reply_t got;
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.new_id        = m_tdata[OBJ_ID_W-1:0];
            got.value_out     = m_tdata[OBJ_ID_W +: VALUE_W];
            got.success       = m_tdata[OBJ_ID_W + VALUE_W];
            got.out_of_memory = m_tdata[OBJ_ID_W + VALUE_W + 1];
            if (table_replies.size() == 0) begin
                report_mismatch("unexpected result word, value_out", got.value_out, '0);
            end else begin
                want = table_replies.pop_front();
                if (got.new_id !== want.new_id)
                    report_mismatch("new_id", VALUE_W'(got.new_id), VALUE_W'(want.new_id));
                if (got.value_out !== want.value_out)
                    report_mismatch("value_out", got.value_out, want.value_out);
                if (got.success !== want.success)
                    report_mismatch("success", VALUE_W'(got.success), VALUE_W'(want.success));
                if (got.out_of_memory !== want.out_of_memory)
                    report_mismatch("out_of_memory", VALUE_W'(got.out_of_memory),
                                    VALUE_W'(want.out_of_memory));
                replies_checked++;
            end
        end
    end

    initial begin
        #8_000_000;
        $display("timeout with %0d result words outstanding", table_replies.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        reset_table_model();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        sender_busy_pct = 30;
        recv_busy_pct   = 30;
        test_reset_chain();
        test_alloc_free();
        test_out_of_memory();
        test_cmpxchg();
        test_unknown_func();
        test_backpressure();
        test_random_mix(1400);

        repeat (10) @(posedge aclk);
        $display("sent %0d operation words: %0d allocs granted, %0d out of memory,",
                 ops_sent, alloc_hits, oom_hits);
        $display("%0d/%0d cmpxchg hit/miss; checked %0d result words with %0d mismatches",
                 cas_hits, cas_misses, replies_checked, errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
